@@ src/isu_pkg.sv @@
// Shared types and codes for the interval set union table.
`default_nettype none
package isu_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_COUNT = 2'd3;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_REVERSED = 2'd2;

    localparam int IN_BYTES_BITS  = 72;
    localparam int OUT_BYTES_BITS = 48;
    localparam int TOTAL_BITS     = 33;
    localparam int ENTRY_OUT_BITS = 5;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_ADD,
        OP_REVERSED,
        OP_CHECK,
        OP_COUNT
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LO_RD,
        ST_LO_USE,
        ST_HI_RD,
        ST_HI_USE,
        ST_RESOLVE,
        ST_INS_RD,
        ST_INS_WR,
        ST_MRG_WR,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_CHK_RD,
        ST_CHK_USE,
        ST_SUM_RD,
        ST_SUM_USE,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

@@ src/isu_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module isu_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [isu_pkg::IN_BYTES_BITS-1:0]    s_axis_tdata,
    input  wire                                  i_pop,
    output logic                                 o_valid,
    output isu_pkg::t_op                         o_op,
    output logic [VALUE_BITS-1:0]                o_first,
    output logic [VALUE_BITS-1:0]                o_last
);
    localparam int IW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    logic [IW-1:0]         w_a_ext;
    logic [IW-1:0]         w_b_ext;
    logic [VALUE_BITS-1:0] w_a;
    logic [VALUE_BITS-1:0] w_b;
    isu_pkg::t_op          w_op;
    logic                  w_push;

    isu_pkg::t_op          r_op [2];
    logic [VALUE_BITS-1:0] r_a [2];
    logic [VALUE_BITS-1:0] r_b [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_cnt;

    assign w_a_ext = IW'(s_axis_tdata[33:2]);
    assign w_b_ext = IW'(s_axis_tdata[65:34]);
    assign w_a = w_a_ext[VALUE_BITS-1:0];
    assign w_b = w_b_ext[VALUE_BITS-1:0];

    always_comb begin
        case (s_axis_tdata[1:0])
            isu_pkg::CMD_CLEAR: w_op = isu_pkg::OP_CLEAR;
            isu_pkg::CMD_ADD:   w_op = (w_a > w_b) ? isu_pkg::OP_REVERSED : isu_pkg::OP_ADD;
            isu_pkg::CMD_CHECK: w_op = isu_pkg::OP_CHECK;
            default:            w_op = isu_pkg::OP_COUNT;
        endcase
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push = s_axis_tvalid && s_axis_tready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_op = r_op[r_rp];
    assign o_first = r_a[r_rp];
    assign o_last = r_b[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_op[r_wp] <= w_op;
            r_a[r_wp] <= w_a;
            r_b[r_wp] <= w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

@@ src/isu_back.sv @@
// Back end: walks the interval memory to carry out each queued request.
`default_nettype none
module isu_back #(
    parameter int MAX_INTERVALS = 16,
    parameter int VALUE_BITS    = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  isu_pkg::t_op                         i_op,
    input  wire  [VALUE_BITS-1:0]                i_first,
    input  wire  [VALUE_BITS-1:0]                i_last,
    output logic                                 o_pop,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [isu_pkg::OUT_BYTES_BITS-1:0]   m_axis_tdata
);
    localparam int IB = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CB = $clog2(MAX_INTERVALS + 1);
    localparam int VB = VALUE_BITS;
    localparam int SW = (VB + 1 > isu_pkg::TOTAL_BITS) ? VB + 1 : isu_pkg::TOTAL_BITS;
    localparam int EW = (CB > isu_pkg::ENTRY_OUT_BITS) ? CB : isu_pkg::ENTRY_OUT_BITS;

    logic [2*VB-1:0] mem [MAX_INTERVALS];
    logic [2*VB-1:0] r_rdata;

    isu_pkg::t_state r_st, n_st;
    logic [VB-1:0]   r_a, n_a, r_b, n_b, r_s_lo, n_s_lo, r_e_last, n_e_last;
    logic [CB-1:0]   r_n, n_n, r_idx, n_idx, r_lo, n_lo, r_hi, n_hi, r_dst, n_dst;
    logic            r_member, n_member;
    logic [isu_pkg::TOTAL_BITS-1:0] r_total, n_total;
    logic [1:0]      r_status, n_status;
    logic            r_ov;
    logic [isu_pkg::OUT_BYTES_BITS-1:0] r_out;
    logic            w_load;

    logic            w_we;
    logic [CB-1:0]   w_wa;
    logic [2*VB-1:0] w_wd;
    logic [CB-1:0]   w_ra;
    logic [VB-1:0]   w_start, w_end;
    logic [SW-1:0]   w_len;
    logic [EW-1:0]   w_n_ext;

    assign w_start = r_rdata[2*VB-1:VB];
    assign w_end = r_rdata[VB-1:0];
    assign w_len = SW'(w_end) - SW'(w_start) + SW'(1);
    assign w_ra = (r_st == isu_pkg::ST_INS_RD) ? r_idx - CB'(1) : r_idx;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa[IB-1:0]] <= w_wd;
        end
        r_rdata <= mem[w_ra[IB-1:0]];
    end

    always_comb begin
        n_st = r_st;
        n_a = r_a;
        n_b = r_b;
        n_s_lo = r_s_lo;
        n_e_last = r_e_last;
        n_n = r_n;
        n_idx = r_idx;
        n_lo = r_lo;
        n_hi = r_hi;
        n_dst = r_dst;
        n_member = r_member;
        n_total = r_total;
        n_status = r_status;
        o_pop = 1'b0;
        w_we = 1'b0;
        w_wa = r_idx;
        w_wd = r_rdata;
        w_load = 1'b0;
        case (r_st)
            isu_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_a = i_first;
                    n_b = i_last;
                    n_idx = '0;
                    n_member = 1'b0;
                    n_total = '0;
                    n_status = isu_pkg::STATUS_DONE;
                    case (i_op)
                        isu_pkg::OP_CLEAR: begin
                            n_n = '0;
                            n_st = isu_pkg::ST_DONE;
                        end
                        isu_pkg::OP_REVERSED: begin
                            n_status = isu_pkg::STATUS_REVERSED;
                            n_st = isu_pkg::ST_DONE;
                        end
                        isu_pkg::OP_ADD:   n_st = isu_pkg::ST_LO_RD;
                        isu_pkg::OP_CHECK: n_st = isu_pkg::ST_CHK_RD;
                        default:           n_st = isu_pkg::ST_SUM_RD;
                    endcase
                end
            end
            isu_pkg::ST_LO_RD: begin
                if (r_idx == r_n) begin
                    n_lo = r_n;
                    n_st = isu_pkg::ST_RESOLVE;
                end else begin
                    n_st = isu_pkg::ST_LO_USE;
                end
            end
            isu_pkg::ST_LO_USE: begin
                if ({1'b0, w_end} + (VB+1)'(1) < {1'b0, r_a}) begin
                    n_idx = r_idx + CB'(1);
                    n_st = isu_pkg::ST_LO_RD;
                end else begin
                    n_lo = r_idx;
                    n_st = isu_pkg::ST_HI_USE;
                end
            end
            isu_pkg::ST_HI_RD: begin
                if (r_idx == r_n) begin
                    n_st = isu_pkg::ST_RESOLVE;
                end else begin
                    n_st = isu_pkg::ST_HI_USE;
                end
            end
            isu_pkg::ST_HI_USE: begin
                if ({1'b0, w_start} <= {1'b0, r_b} + (VB+1)'(1)) begin
                    if (r_idx == r_lo) begin
                        n_s_lo = w_start;
                    end
                    n_e_last = w_end;
                    n_idx = r_idx + CB'(1);
                    n_st = isu_pkg::ST_HI_RD;
                end else begin
                    n_st = isu_pkg::ST_RESOLVE;
                end
            end
            isu_pkg::ST_RESOLVE: begin
                if (r_idx == r_lo) begin
                    if (r_n == CB'(MAX_INTERVALS)) begin
                        n_status = isu_pkg::STATUS_FULL;
                        n_st = isu_pkg::ST_DONE;
                    end else begin
                        n_idx = r_n;
                        n_st = isu_pkg::ST_INS_RD;
                    end
                end else begin
                    n_hi = r_idx;
                    n_st = isu_pkg::ST_MRG_WR;
                end
            end
            isu_pkg::ST_INS_RD: begin
                if (r_idx == r_lo) begin
                    w_we = 1'b1;
                    w_wa = r_lo;
                    w_wd = {r_a, r_b};
                    n_n = r_n + CB'(1);
                    n_st = isu_pkg::ST_DONE;
                end else begin
                    n_st = isu_pkg::ST_INS_WR;
                end
            end
            isu_pkg::ST_INS_WR: begin
                w_we = 1'b1;
                w_wa = r_idx;
                n_idx = r_idx - CB'(1);
                n_st = isu_pkg::ST_INS_RD;
            end
            isu_pkg::ST_MRG_WR: begin
                w_we = 1'b1;
                w_wa = r_lo;
                w_wd = {(r_s_lo < r_a) ? r_s_lo : r_a, (r_e_last > r_b) ? r_e_last : r_b};
                n_dst = r_lo + CB'(1);
                n_idx = r_hi;
                n_st = isu_pkg::ST_CMP_RD;
            end
            isu_pkg::ST_CMP_RD: begin
                if (r_idx == r_n) begin
                    n_n = r_dst;
                    n_st = isu_pkg::ST_DONE;
                end else begin
                    n_st = isu_pkg::ST_CMP_WR;
                end
            end
            isu_pkg::ST_CMP_WR: begin
                w_we = 1'b1;
                w_wa = r_dst;
                n_dst = r_dst + CB'(1);
                n_idx = r_idx + CB'(1);
                n_st = isu_pkg::ST_CMP_RD;
            end
            isu_pkg::ST_CHK_RD: begin
                n_st = (r_idx == r_n) ? isu_pkg::ST_DONE : isu_pkg::ST_CHK_USE;
            end
            isu_pkg::ST_CHK_USE: begin
                if (r_a >= w_start && r_a <= w_end) begin
                    n_member = 1'b1;
                    n_st = isu_pkg::ST_DONE;
                end else begin
                    n_idx = r_idx + CB'(1);
                    n_st = isu_pkg::ST_CHK_RD;
                end
            end
            isu_pkg::ST_SUM_RD: begin
                n_st = (r_idx == r_n) ? isu_pkg::ST_DONE : isu_pkg::ST_SUM_USE;
            end
            isu_pkg::ST_SUM_USE: begin
                n_total = r_total + w_len[isu_pkg::TOTAL_BITS-1:0];
                n_idx = r_idx + CB'(1);
                n_st = isu_pkg::ST_SUM_RD;
            end
            isu_pkg::ST_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    w_load = 1'b1;
                    n_st = isu_pkg::ST_IDLE;
                end
            end
            default: n_st = isu_pkg::ST_IDLE;
        endcase
    end

    assign w_n_ext = EW'(r_n);

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_s_lo <= n_s_lo;
        r_e_last <= n_e_last;
        r_idx <= n_idx;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_dst <= n_dst;
        r_member <= n_member;
        r_total <= n_total;
        r_status <= n_status;
        if (w_load) begin
            r_out <= {7'd0, w_n_ext[isu_pkg::ENTRY_OUT_BITS-1:0], r_total, r_member, r_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= isu_pkg::ST_IDLE;
            r_n <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_n <= n_n;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;
endmodule
`default_nettype wire

@@ src/interval_set_union_table_unit.sv @@
// Clear and reversed add go straight to the result; check and count walk the stored intervals.
// Add scans for the overlap, then inserts by shifting entries up or merges and compacts.
// Throughput is one request at a time in the back end; each entry visit takes a registered
// memory read and a use step. A two-entry queue accepts requests while the back end is busy.
// Synchronous active-low reset empties the table and the queue; the memory is not cleared.
`default_nettype none
module interval_set_union_table_unit #(
    parameter int MAX_INTERVALS = 16,
    parameter int VALUE_BITS    = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,   // command[1:0], first_value[33:2], last_value[65:34]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[1:0], is_member[2], covered_total[35:3],
                                        // entries_used[40:36]
);
    logic                  w_valid;
    logic                  w_pop;
    isu_pkg::t_op          w_op;
    logic [VALUE_BITS-1:0] w_first;
    logic [VALUE_BITS-1:0] w_last;

    isu_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .i_pop(w_pop),
        .o_valid(w_valid),
        .o_op(w_op),
        .o_first(w_first),
        .o_last(w_last)
    );

    isu_back #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_valid),
        .i_op(w_op),
        .i_first(w_first),
        .i_last(w_last),
        .o_pop(w_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );
endmodule
`default_nettype wire
